// ===== rtl/rk4ho_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RK4 harmonic oscillator package
// Payload types, register indexes, fixed-point constants and the control
// store of the microcoded integrator sequencer.
// ----------------------------------------------------------------------------
package rk4ho_pkg;

   // Field widths
   localparam int DATA_W      = 32;
   localparam int STEP_W      = 24;
   localparam int OMEGA_W     = 31;
   localparam int COUNT_W     = 16;
   localparam int STATE_DIM   = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Internal arithmetic widths
   localparam int PROD_W  = 2 * DATA_W;
   localparam int WIDE_W  = 41;
   localparam int SUM_W   = 36;
   localparam int DIV_W   = 40;
   localparam int QUO_W   = 34;
   localparam int DIGIT_W = 8;
   localparam int REM_W   = 2;
   localparam int DVAL_W  = DIGIT_W + REM_W;
   localparam int DMUL_W  = 20;
   localparam int TACC_W  = 42;

   localparam int DIV_STEPS = DIV_W / DIGIT_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   // Q8.24 rounding and clamping constants
   localparam int FRAC_BITS = 24;
   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'sd8388608);
   localparam logic signed [DATA_W-1:0] S32_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] S32_MIN   = 32'sh8000_0000;
   localparam logic signed [WIDE_W-1:0] WIDE_S32_MAX = WIDE_W'(64'sd2147483647);
   localparam logic signed [WIDE_W-1:0] WIDE_S32_MIN = WIDE_W'(-64'sd2147483648);
   localparam logic signed [WIDE_W-1:0] WIDE_ONE     = WIDE_W'(64'sd1);
   localparam logic signed [WIDE_W-1:0] WIDE_TWO32   = WIDE_W'(64'sd4294967296);

   // Division by six: the sum plus three is biased by 6 * 2^32 so that the
   // dividend is positive, halved, then divided by three a byte at a time.
   localparam logic signed [SUM_W:0] DIV_BIAS = (SUM_W+1)'(64'sd25769803779);
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;
   localparam int DIVISOR3     = 3;

   // Time keeping, Q0.24 step into Q16.16 time
   localparam int TIME_SHIFT = 8;
   localparam int TIME_ROUND = 128;
   localparam logic [DATA_W-1:0] TIME_MAX = 32'hFFFF_FFFF;

   // Register reset values
   localparam logic [STEP_W-1:0]  TIME_STEP_RESET   = 24'd16777;
   localparam logic [OMEGA_W-1:0] OMEGA_SQ_RESET    = 31'd16777216;
   localparam logic [DATA_W-1:0]  START_TIME_RESET  = 32'd0;
   localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 16'd1001;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIME_STEP   = 2'd0,
      CSR_OMEGA_SQ    = 2'd1,
      CSR_START_TIME  = 2'd2,
      CSR_POINT_COUNT = 2'd3
   } csr_index_type;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef struct packed {
      logic                     kind;
      logic signed [DATA_W-1:0] position_in;
      logic signed [DATA_W-1:0] velocity_in;
   } req_type;

   typedef struct packed {
      logic        [DATA_W-1:0] time_out;
      logic signed [DATA_W-1:0] position_out;
      logic signed [DATA_W-1:0] velocity_out;
      logic                     last_point;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] value;
   } clamp_type;

   function automatic clamp_type clamp32(input logic signed [WIDE_W-1:0] v);
      clamp_type r;
      if (v > WIDE_S32_MAX) begin
         r.hit   = 1'b1;
         r.value = S32_MAX;
      end else if (v < WIDE_S32_MIN) begin
         r.hit   = 1'b1;
         r.value = S32_MIN;
      end else begin
         r.hit   = 1'b0;
         r.value = $signed(v[DATA_W-1:0]);
      end
      return r;
   endfunction

   // Control store
   localparam int UCODE_DEPTH = 28;
   localparam int PC_W        = $clog2(UCODE_DEPTH);

   localparam logic [PC_W-1:0] UA_START = PC_W'(0);
   localparam logic [PC_W-1:0] UA_DIV   = PC_W'(24);
   localparam logic [PC_W-1:0] UA_FINAL = PC_W'(25);
   localparam logic [PC_W-1:0] UA_LOAD  = PC_W'(26);
   localparam logic [PC_W-1:0] UA_DONE  = PC_W'(27);

   typedef enum logic [1:0] {MA_MID0, MA_MID1, MA_ACC, MA_COUNT} mul_a_type;
   typedef enum logic {MB_OMEGA, MB_STEP} mul_b_type;
   typedef enum logic [1:0] {WB_NONE, WB_ACC, WB_K0, WB_K1} wb_type;
   typedef enum logic [1:0] {MID_NONE, MID_COPY, MID_HALF, MID_FULL} mid_op_type;
   typedef enum logic [1:0] {SUM_NONE, SUM_CLEAR, SUM_ONCE, SUM_TWICE} sum_op_type;
   typedef enum logic [2:0] {
      MISC_NONE, MISC_LOAD, MISC_TIME, MISC_DIV_INIT, MISC_DIV_STEP, MISC_FINAL, MISC_DONE
   } misc_type;
   typedef enum logic [2:0] {
      CND_NEVER, CND_ALWAYS, CND_LOAD, CND_HOLD, CND_DIV_MORE, CND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      mul_a_type        mul_a;
      mul_b_type        mul_b;
      wb_type           wb;
      mid_op_type       mid_op;
      sum_op_type       sum_op;
      misc_type         misc;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ucode_type;

   localparam ucode_type UC_NOP = '{
      mul_a: MA_MID0, mul_b: MB_OMEGA, wb: WB_NONE, mid_op: MID_NONE,
      sum_op: SUM_NONE, misc: MISC_NONE, cond: CND_NEVER, target: UA_START
   };

   // One slope evaluation is four words: w^2 * x, then x' and v' scaled by dt.
   function automatic ucode_type ucode_word(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = UC_NOP;
      unique case (pc) inside
         PC_W'(0): begin
            w.cond   = CND_LOAD;
            w.target = UA_LOAD;
         end
         PC_W'(1): begin
            w.cond   = CND_HOLD;
            w.target = UA_DONE;
            w.mid_op = MID_COPY;
            w.sum_op = SUM_CLEAR;
         end
         PC_W'(2), PC_W'(7), PC_W'(12), PC_W'(17): begin
            w.mul_a = MA_MID0;
            w.mul_b = MB_OMEGA;
         end
         PC_W'(3), PC_W'(8), PC_W'(13), PC_W'(18): begin
            w.wb    = WB_ACC;
            w.mul_a = MA_MID1;
            w.mul_b = MB_STEP;
         end
         PC_W'(4), PC_W'(9), PC_W'(14), PC_W'(19): begin
            w.wb    = WB_K0;
            w.mul_a = MA_ACC;
            w.mul_b = MB_STEP;
         end
         PC_W'(5), PC_W'(10), PC_W'(15), PC_W'(20): begin
            w.wb = WB_K1;
         end
         PC_W'(6): begin
            w.sum_op = SUM_ONCE;
            w.mid_op = MID_HALF;
         end
         PC_W'(11): begin
            w.sum_op = SUM_TWICE;
            w.mid_op = MID_HALF;
         end
         PC_W'(16): begin
            w.sum_op = SUM_TWICE;
            w.mid_op = MID_FULL;
         end
         PC_W'(21): begin
            w.sum_op = SUM_ONCE;
            w.mul_a  = MA_COUNT;
            w.mul_b  = MB_STEP;
         end
         PC_W'(22): begin
            w.misc = MISC_TIME;
         end
         PC_W'(23): begin
            w.misc = MISC_DIV_INIT;
         end
         UA_DIV: begin
            w.misc   = MISC_DIV_STEP;
            w.cond   = CND_DIV_MORE;
            w.target = UA_DIV;
         end
         UA_FINAL: begin
            w.misc   = MISC_FINAL;
            w.cond   = CND_ALWAYS;
            w.target = UA_DONE;
         end
         UA_LOAD: begin
            w.misc = MISC_LOAD;
         end
         UA_DONE: begin
            w.misc   = MISC_DONE;
            w.cond   = CND_OUT_BUSY;
            w.target = UA_DONE;
         end
         default: begin
            w = UC_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/rk4_harmonic_oscillator_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RK4 harmonic oscillator step
// Fixed-step fourth-order Runge-Kutta integrator for x'' = -w^2 x in signed
// Q8.24, driven by a microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// A load request sets position and velocity, sets the time to start_time and
// restarts the point count; a step request advances the state by one RK4 step
// of width time_step. Every request gives exactly one response holding time,
// position, velocity, a last-point flag and a flag that is set when any
// arithmetic in the step saturated. Once the configured number of points has
// been reached, step requests return the held state unchanged. A step request
// keeps the block busy, stalling new requests, until its response is written;
// load requests and held steps skip the slope and divide words. The length
// of a step is set by the single 32 x 32 multiplier, which the control program
// uses thirteen times in sequence, and by the byte-wide divide-by-three loop
// of five passes. A finished response waits in an output register, so the
// block takes the next request while the previous response is still stalled.
module rk4_harmonic_oscillator_step (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rk4ho_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rk4ho_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_write,
   input  logic [rk4ho_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rk4ho_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import rk4ho_pkg::*;

   // Configuration
   logic [STEP_W-1:0]  time_step_ff,   time_step_in;
   logic [OMEGA_W-1:0] omega_sq_ff,    omega_sq_in;
   logic [DATA_W-1:0]  start_time_ff,  start_time_in;
   logic [COUNT_W-1:0] point_count_ff, point_count_in;

   // Integrator state
   logic signed [DATA_W-1:0] y_ff [STATE_DIM];
   logic signed [DATA_W-1:0] y_in [STATE_DIM];
   logic [DATA_W-1:0]  time_ff, time_in;
   logic [COUNT_W-1:0] done_ff, done_in;

   // Sequencer
   logic             busy_ff, busy_in;
   logic [PC_W-1:0]  pc_ff,   pc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             sat_ff, sat_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Datapath registers
   req_type                  req_ff,  req_in;
   rsp_type                  rsp_ff,  rsp_in;
   logic signed [DATA_W-1:0] mid_ff [STATE_DIM];
   logic signed [DATA_W-1:0] mid_in [STATE_DIM];
   logic signed [DATA_W-1:0] k_ff   [STATE_DIM];
   logic signed [DATA_W-1:0] k_in   [STATE_DIM];
   logic signed [SUM_W-1:0]  sum_ff [STATE_DIM];
   logic signed [SUM_W-1:0]  sum_in [STATE_DIM];
   logic [DIV_W-1:0]         quo_ff [STATE_DIM];
   logic [DIV_W-1:0]         quo_in [STATE_DIM];
   logic [REM_W-1:0]         rem_ff [STATE_DIM];
   logic [REM_W-1:0]         rem_in [STATE_DIM];
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // Combinational values
   ucode_type                uc;
   logic                     req_accept;
   logic                     out_busy;
   logic                     last_now;
   logic                     jump;
   logic signed [DATA_W-1:0] mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] rnd_full;
   clamp_type                rnd_c;
   clamp_type                neg_c;
   clamp_type                half_c [STATE_DIM];
   clamp_type                full_c [STATE_DIM];
   clamp_type                fin_c  [STATE_DIM];
   logic signed [SUM_W:0]    div_u  [STATE_DIM];
   logic [DVAL_W-1:0]        div_val [STATE_DIM];
   logic [DMUL_W-1:0]        div_mul [STATE_DIM];
   logic [DIGIT_W-1:0]       div_q   [STATE_DIM];
   logic [DVAL_W-1:0]        div_three [STATE_DIM];
   logic [DATA_W+8-1:0]      step_base;
   logic [TACC_W-1:0]        time_sum;

   assign uc         = ucode_word(pc_ff);
   assign req_accept = req_valid && !busy_ff;
   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign last_now   = ({1'b0, done_ff} + (COUNT_W+1)'(1)) >= {1'b0, point_count_ff};
   assign req_stall  = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Shared multiplier operands
   always_comb begin
      case (uc.mul_a)
         MA_MID0:  mul_a = mid_ff[0];
         MA_MID1:  mul_a = mid_ff[1];
         MA_ACC:   mul_a = acc_ff;
         MA_COUNT: mul_a = $signed({{(DATA_W-COUNT_W){1'b0}}, done_ff});
         default:  mul_a = mid_ff[0];
      endcase
      case (uc.mul_b)
         MB_OMEGA: mul_b = $signed({1'b0, omega_sq_ff});
         MB_STEP:  mul_b = $signed({{(DATA_W-STEP_W){1'b0}}, time_step_ff});
         default:  mul_b = $signed({1'b0, omega_sq_ff});
      endcase
      prod_in = mul_a * mul_b;
   end

   // Rounding of the registered product back to Q8.24
   always_comb begin
      rnd_full = (prod_ff + PROD_HALF) >>> FRAC_BITS;
      rnd_c    = clamp32(WIDE_W'(rnd_full));
      neg_c    = clamp32(-WIDE_W'($signed(rnd_c.value)));
   end

   // Per-component arithmetic
   always_comb begin
      for (int j = 0; j < STATE_DIM; j++) begin
         half_c[j] = clamp32(WIDE_W'(y_ff[j])
                             + ((WIDE_W'(k_ff[j]) + WIDE_ONE) >>> 1));
         full_c[j] = clamp32(WIDE_W'(y_ff[j]) + WIDE_W'(k_ff[j]));
         fin_c[j]  = clamp32(WIDE_W'(y_ff[j])
                             + WIDE_W'($signed({1'b0, quo_ff[j][QUO_W-1:0]}))
                             - WIDE_TWO32);
         div_u[j]     = (SUM_W+1)'(sum_ff[j]) + DIV_BIAS;
         div_val[j]   = {rem_ff[j], quo_ff[j][DIV_W-1 -: DIGIT_W]};
         div_mul[j]   = DMUL_W'(div_val[j]) * DMUL_W'(RECIP3);
         div_q[j]     = DIGIT_W'(div_mul[j] >> RECIP3_SHIFT);
         div_three[j] = DVAL_W'(div_q[j]) * DVAL_W'(DIVISOR3);
      end
   end

   // Time advance: the product register holds points_done * dt here.
   always_comb begin
      step_base = prod_ff[DATA_W+8-1:0];
      time_sum  = TACC_W'(time_ff)
                  + (((TACC_W'(step_base) + TACC_W'(time_step_ff) + TACC_W'(TIME_ROUND))
                      >> TIME_SHIFT)
                     - ((TACC_W'(step_base) + TACC_W'(TIME_ROUND)) >> TIME_SHIFT));
   end

   always_comb begin
      case (uc.cond)
         CND_NEVER:    jump = 1'b0;
         CND_ALWAYS:   jump = 1'b1;
         CND_LOAD:     jump = (req_ff.kind == KIND_LOAD);
         CND_HOLD:     jump = last_now;
         CND_DIV_MORE: jump = (div_cnt_ff != '0);
         CND_OUT_BUSY: jump = out_busy;
         default:      jump = 1'b0;
      endcase
   end

   // Next-state logic
   always_comb begin
      time_step_in   = time_step_ff;
      omega_sq_in    = omega_sq_ff;
      start_time_in  = start_time_ff;
      point_count_in = point_count_ff;
      time_in        = time_ff;
      done_in        = done_ff;
      busy_in        = busy_ff;
      pc_in          = pc_ff;
      rsp_valid_in   = rsp_valid_ff;
      sat_in         = sat_ff;
      div_cnt_in     = div_cnt_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      acc_in         = acc_ff;
      for (int j = 0; j < STATE_DIM; j++) begin
         y_in[j]   = y_ff[j];
         mid_in[j] = mid_ff[j];
         k_in[j]   = k_ff[j];
         sum_in[j] = sum_ff[j];
         quo_in[j] = quo_ff[j];
         rem_in[j] = rem_ff[j];
      end

      if (csr_write) begin
         unique case (csr_index)
            CSR_TIME_STEP:   time_step_in   = csr_wdata[STEP_W-1:0];
            CSR_OMEGA_SQ:    omega_sq_in    = csr_wdata[OMEGA_W-1:0];
            CSR_START_TIME:  start_time_in  = csr_wdata[DATA_W-1:0];
            CSR_POINT_COUNT: point_count_in = csr_wdata[COUNT_W-1:0];
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         req_in  = req_data;
         busy_in = 1'b1;
         pc_in   = UA_START;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         pc_in = jump ? uc.target : pc_ff + PC_W'(1);

         case (uc.wb)
            WB_NONE: ;
            WB_ACC: begin
               acc_in = neg_c.value;
               sat_in = sat_in | rnd_c.hit | neg_c.hit;
            end
            WB_K0: begin
               k_in[0] = rnd_c.value;
               sat_in  = sat_in | rnd_c.hit;
            end
            WB_K1: begin
               k_in[1] = rnd_c.value;
               sat_in  = sat_in | rnd_c.hit;
            end
            default: ;
         endcase

         for (int j = 0; j < STATE_DIM; j++) begin
            case (uc.mid_op)
               MID_NONE: ;
               MID_COPY: mid_in[j] = y_ff[j];
               MID_HALF: begin
                  mid_in[j] = half_c[j].value;
                  sat_in    = sat_in | half_c[j].hit;
               end
               MID_FULL: begin
                  mid_in[j] = full_c[j].value;
                  sat_in    = sat_in | full_c[j].hit;
               end
               default: ;
            endcase
            case (uc.sum_op)
               SUM_NONE:  ;
               SUM_CLEAR: sum_in[j] = '0;
               SUM_ONCE:  sum_in[j] = sum_ff[j] + SUM_W'(k_ff[j]);
               SUM_TWICE: sum_in[j] = sum_ff[j] + (SUM_W'(k_ff[j]) <<< 1);
               default:   ;
            endcase
         end

         case (uc.misc)
            MISC_NONE: ;
            MISC_LOAD: begin
               y_in[0] = req_ff.position_in;
               y_in[1] = req_ff.velocity_in;
               time_in = start_time_ff;
               done_in = '0;
            end
            MISC_TIME: begin
               if (time_sum[TACC_W-1:DATA_W] != '0) begin
                  time_in = TIME_MAX;
                  sat_in  = 1'b1;
               end else begin
                  time_in = time_sum[DATA_W-1:0];
               end
               done_in = done_ff + COUNT_W'(1);
            end
            MISC_DIV_INIT: begin
               // Dividend is the biased sum halved; the byte loop divides by three.
               for (int j = 0; j < STATE_DIM; j++) begin
                  quo_in[j] = DIV_W'(div_u[j][SUM_W-1:1]);
                  rem_in[j] = '0;
               end
               div_cnt_in = DCNT_W'(DIV_STEPS - 1);
            end
            MISC_DIV_STEP: begin
               for (int j = 0; j < STATE_DIM; j++) begin
                  quo_in[j] = {quo_ff[j][DIV_W-DIGIT_W-1:0], div_q[j]};
                  rem_in[j] = REM_W'(div_val[j] - div_three[j]);
               end
               div_cnt_in = div_cnt_ff - DCNT_W'(1);
            end
            MISC_FINAL: begin
               for (int j = 0; j < STATE_DIM; j++) begin
                  y_in[j] = fin_c[j].value;
                  sat_in  = sat_in | fin_c[j].hit;
               end
            end
            MISC_DONE: begin
               if (!out_busy) begin
                  rsp_in.time_out     = time_ff;
                  rsp_in.position_out = y_ff[0];
                  rsp_in.velocity_out = y_ff[1];
                  rsp_in.last_point   = last_now;
                  rsp_in.saturated    = sat_ff;
                  rsp_valid_in        = 1'b1;
                  busy_in             = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= TIME_STEP_RESET;
         omega_sq_ff    <= OMEGA_SQ_RESET;
         start_time_ff  <= START_TIME_RESET;
         point_count_ff <= POINT_COUNT_RESET;
         for (int j = 0; j < STATE_DIM; j++) begin
            y_ff[j] <= '0;
         end
         time_ff      <= '0;
         done_ff      <= '0;
         busy_ff      <= 1'b0;
         pc_ff        <= UA_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_step_ff   <= time_step_in;
         omega_sq_ff    <= omega_sq_in;
         start_time_ff  <= start_time_in;
         point_count_ff <= point_count_in;
         for (int j = 0; j < STATE_DIM; j++) begin
            y_ff[j] <= y_in[j];
         end
         time_ff      <= time_in;
         done_ff      <= done_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      sat_ff     <= sat_in;
      div_cnt_ff <= div_cnt_in;
      for (int j = 0; j < STATE_DIM; j++) begin
         mid_ff[j] <= mid_in[j];
         k_ff[j]   <= k_in[j];
         sum_ff[j] <= sum_in[j];
         quo_ff[j] <= quo_in[j];
         rem_ff[j] <= rem_in[j];
      end
   end

   // An accepted request always starts the program at its first word.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> busy_ff && pc_ff == UA_START)
      else $error("accepted request did not start the sequencer");

   // The sequencer only goes idle from the response word.
   a_idle_from_done: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy_ff) |-> $past(pc_ff) == UA_DONE)
      else $error("sequencer went idle outside the response word");

   // The divide loop leaves to the final update once its count runs out.
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      busy_ff && pc_ff == UA_DIV && div_cnt_ff == '0 |=> pc_ff == UA_FINAL)
      else $error("divide loop did not exit to the final update");

   // With the output register free, the response word delivers and finishes.
   a_response_written: assert property (@(posedge clock) disable iff (reset)
      busy_ff && pc_ff == UA_DONE && !(rsp_valid_ff && rsp_stall)
      |=> rsp_valid_ff && !busy_ff)
      else $error("response word did not fill the output register");

endmodule

// ===== verif/rk4_harmonic_oscillator_step_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RK4 harmonic oscillator step testbench
// Drives load and step requests through the request channel, keeps its own
// fixed-point RK4 integrator to predict every response, and checks each
// response field by field under random request gaps and response stalls.
// ----------------------------------------------------------------------------
module rk4_harmonic_oscillator_step_tb;
   import rk4ho_pkg::*;

   localparam int     CYCLE_LIMIT   = 1_000_000;
   localparam int     SETTLE_CYCLES = 40;
   localparam int     RANDOM_PHASES = 6;
   localparam int     PHASE_ITEMS   = 170;
   localparam int     HOLD_AFTER    = 300;
   localparam int     HOLD_CYCLES   = 600;
   localparam longint Q_MAX  = 64'sd2147483647;
   localparam longint Q_MIN  = -64'sd2147483648;
   localparam longint Q_HALF = 64'sd8388608;

   typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rk4_harmonic_oscillator_step dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mirror of the registers and of the integrator state.
   logic [STEP_W-1:0]  cfg_step   = TIME_STEP_RESET;
   logic [OMEGA_W-1:0] cfg_omega  = OMEGA_SQ_RESET;
   logic [DATA_W-1:0]  cfg_start  = START_TIME_RESET;
   logic [COUNT_W-1:0] cfg_points = POINT_COUNT_RESET;
   longint             osc_pos  = 0;
   longint             osc_vel  = 0;
   logic [DATA_W-1:0]  osc_time = '0;
   logic [COUNT_W-1:0] osc_done = '0;
   logic               clamp_seen;

   req_type     pending_reqs[$];
   rsp_type     expected_points[$];
   int unsigned reqs_queued   = 0;
   int unsigned reqs_accepted = 0;
   int unsigned rsp_seen      = 0;
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   logic        req_taken     = 1'b0;

   function automatic longint sat32(longint v);
      if (v > Q_MAX) begin
         clamp_seen = 1'b1;
         return Q_MAX;
      end
      if (v < Q_MIN) begin
         clamp_seen = 1'b1;
         return Q_MIN;
      end
      return v;
   endfunction

   // Q8.24 product, rounded to nearest with ties upwards.
   function automatic longint fix_mul(longint a, longint b);
      return sat32((a * b + Q_HALF) >>> FRAC_BITS);
   endfunction

   function automatic longint div6_floor(longint q);
      if (q >= 0) return q / 6;
      return -(((-q) - 1) / 6) - 1;
   endfunction

   // Derivative of position and velocity, already scaled by the step width.
   function automatic void scaled_slope(input longint p, input longint v,
                                        output longint dp, output longint dv);
      longint accel, omega_l, step_l;
      omega_l = {33'd0, cfg_omega};
      step_l  = {40'd0, cfg_step};
      accel   = sat32(-fix_mul(p, omega_l));
      dp      = fix_mul(v, step_l);
      dv      = fix_mul(accel, step_l);
   endfunction

   function automatic void rk4_advance();
      longint k1p, k1v, k2p, k2v, k3p, k3v, k4p, k4v, mp, mv;
      longint unsigned done_l, step_l, before_l, after_l, t;
      scaled_slope(osc_pos, osc_vel, k1p, k1v);
      mp = sat32(osc_pos + ((k1p + 1) >>> 1));
      mv = sat32(osc_vel + ((k1v + 1) >>> 1));
      scaled_slope(mp, mv, k2p, k2v);
      mp = sat32(osc_pos + ((k2p + 1) >>> 1));
      mv = sat32(osc_vel + ((k2v + 1) >>> 1));
      scaled_slope(mp, mv, k3p, k3v);
      mp = sat32(osc_pos + k3p);
      mv = sat32(osc_vel + k3v);
      scaled_slope(mp, mv, k4p, k4v);
      osc_pos = sat32(osc_pos + div6_floor(k1p + 2 * k2p + 2 * k3p + k4p + 3));
      osc_vel = sat32(osc_vel + div6_floor(k1v + 2 * k2v + 2 * k3v + k4v + 3));
      // The time follows the rounded running product of count and step, so
      // rounding errors do not pile up over a long run.
      done_l   = osc_done;
      step_l   = cfg_step;
      before_l = done_l * step_l;
      after_l  = before_l + step_l;
      t = osc_time + (((after_l + 128) >> 8) - ((before_l + 128) >> 8));
      if (t > 64'hFFFF_FFFF) begin
         clamp_seen = 1'b1;
         t = 64'hFFFF_FFFF;
      end
      osc_time = t[DATA_W-1:0];
      osc_done = osc_done + 16'd1;
   endfunction

   function automatic rsp_type oscillator_next(req_type r);
      rsp_type o;
      clamp_seen = 1'b0;
      if (r.kind == KIND_LOAD) begin
         osc_pos  = $signed(r.position_in);
         osc_vel  = $signed(r.velocity_in);
         osc_time = cfg_start;
         osc_done = '0;
      end else if ({1'b0, osc_done} + 17'd1 < {1'b0, cfg_points}) begin
         rk4_advance();
      end
      o.time_out     = osc_time;
      o.position_out = osc_pos[DATA_W-1:0];
      o.velocity_out = osc_vel[DATA_W-1:0];
      o.last_point   = ({1'b0, osc_done} + 17'd1 >= {1'b0, cfg_points});
      o.saturated    = clamp_seen;
      return o;
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   int unsigned burst_left = 8;
   int unsigned gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall pattern, with one long hold-off so that the block backs up.
   flow_mode_type flow_mode = FLOW_FREE;
   int unsigned   mode_left = 0;
   int unsigned   hold_left = 0;
   logic          hold_done = 1'b0;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            flow_mode = flow_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 150);
         end else begin
            mode_left--;
         end
         case (flow_mode)
            FLOW_FREE: begin
               rsp_stall <= 1'b0;
            end
            FLOW_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 9) < 3);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 9) < 8);
            end
         endcase
      end
   end

   // Prediction on every accepted request, checking on every accepted response.
   always @(posedge clock) begin : monitor_blk
      rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_points.push_back(oscillator_next(req_data));
         reqs_accepted++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_points.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.time_out !== want.time_out) begin
               $error("time_out: expected %h, got %h", want.time_out, rsp_data.time_out);
               error_count++;
            end
            if (rsp_data.position_out !== want.position_out) begin
               $error("position_out: expected %h, got %h",
                      want.position_out, rsp_data.position_out);
               error_count++;
            end
            if (rsp_data.velocity_out !== want.velocity_out) begin
               $error("velocity_out: expected %h, got %h",
                      want.velocity_out, rsp_data.velocity_out);
               error_count++;
            end
            if (rsp_data.last_point !== want.last_point) begin
               $error("last_point: expected %b, got %b", want.last_point, rsp_data.last_point);
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, rsp_data.saturated);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic add_req(logic kind, logic [DATA_W-1:0] p, logic [DATA_W-1:0] v);
      req_type r;
      r.kind        = kind;
      r.position_in = p;
      r.velocity_in = v;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   task automatic wait_idle();
      while (reqs_accepted != reqs_queued || expected_points.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_TIME_STEP: begin
            cfg_step = value[STEP_W-1:0];
         end
         CSR_OMEGA_SQ: begin
            cfg_omega = value[OMEGA_W-1:0];
         end
         CSR_START_TIME: begin
            cfg_start = value;
         end
         default: begin
            cfg_points = value[COUNT_W-1:0];
         end
      endcase
   endtask

   task automatic configure(logic [31:0] step, logic [31:0] omega,
                            logic [31:0] start, logic [31:0] points);
      write_reg(CSR_TIME_STEP, step);
      write_reg(CSR_OMEGA_SQ, omega);
      write_reg(CSR_START_TIME, start);
      write_reg(CSR_POINT_COUNT, points);
      @(negedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly a load followed by a run of steps; now and then a few loose requests.
   task automatic random_phase(int unsigned n_items);
      int unsigned made, steps, j;
      logic [DATA_W-1:0] p, v;
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 1) == 1) begin
               p = $urandom;
               v = $urandom;
            end else begin
               p = $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
               v = $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
            end
            add_req(KIND_LOAD, p, v);
            steps = $urandom_range(1, 40);
            for (j = 0; j < steps; j++) add_req(KIND_STEP, $urandom, $urandom);
            made += steps + 1;
         end else begin
            steps = $urandom_range(1, 5);
            for (j = 0; j < steps; j++)
               add_req(($urandom_range(0, 1) == 1) ? KIND_STEP : KIND_LOAD, $urandom, $urandom);
            made += steps;
         end
      end
   endtask

   initial begin
      int unsigned ph;
      logic [31:0] r_step, r_omega, r_start, r_points;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: steps before any load, then loads at the range limits.
      add_req(KIND_STEP, 32'h1234_5678, 32'h8765_4321);
      add_req(KIND_STEP, 32'hFFFF_FFFF, 32'h0000_0000);
      add_req(KIND_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_LOAD, 32'h0100_0000, 32'h0);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_STEP, 32'h0, 32'h0);
      wait_idle();

      // A short run that goes past its last point and then holds.
      configure(32'd16777, 32'h0100_0000, 32'h0001_0000, 32'd3);
      add_req(KIND_LOAD, 32'h0080_0000, 32'hFF80_0000);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_STEP, 32'h0, 32'h0);
      wait_idle();

      // Point counts of zero and one make every point the last.
      configure(32'd16777, 32'h0100_0000, 32'h0001_0000, 32'd0);
      add_req(KIND_LOAD, 32'h0100_0000, 32'h0100_0000);
      add_req(KIND_STEP, 32'h0, 32'h0);
      wait_idle();
      configure(32'd16777, 32'h0100_0000, 32'h0001_0000, 32'd1);
      add_req(KIND_LOAD, 32'hFF00_0000, 32'h0100_0000);
      add_req(KIND_STEP, 32'h0, 32'h0);
      wait_idle();

      // Zero step width with the largest frequency and the latest start time.
      configure(32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd65535);
      add_req(KIND_LOAD, 32'h0100_0000, 32'hFF00_0000);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_STEP, 32'h0, 32'h0);
      wait_idle();

      // Largest step width from the latest start: the time must clamp.
      configure(32'h00FF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd65535);
      add_req(KIND_LOAD, 32'h4000_0000, 32'h7FFF_FFFF);
      add_req(KIND_STEP, 32'h0, 32'h0);
      add_req(KIND_STEP, 32'h0, 32'h0);
      wait_idle();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 5))
            0: r_step = 32'd1;
            1: r_step = 32'h00FF_FFFF;
            2: r_step = $urandom;
            default: r_step = $urandom_range(1000, 400000);
         endcase
         case ($urandom_range(0, 5))
            0: r_omega = 32'd0;
            1: r_omega = 32'h7FFF_FFFF;
            2: r_omega = $urandom;
            default: r_omega = $urandom_range(0, 32'h1000_0000);
         endcase
         case ($urandom_range(0, 4))
            0: r_start = 32'd0;
            1: r_start = 32'hFFFF_FFFF;
            2: r_start = 32'hFFFF_0000;
            default: r_start = $urandom;
         endcase
         case ($urandom_range(0, 7))
            0: r_points = 32'd2;
            1: r_points = 32'd65535;
            2: r_points = $urandom_range(0, 1);
            default: r_points = $urandom_range(2, 50);
         endcase
         configure(r_step, r_omega, r_start, r_points);
         random_phase(PHASE_ITEMS);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rk4ho_pkg.sv
rtl/rk4_harmonic_oscillator_step.sv
verif/rk4_harmonic_oscillator_step_tb.sv
